// ----- hw/rtl/kdm_pkg.sv -----
`timescale 1ns / 1ps
// kdm_pkg: shared types and constants for the k-way descending merge
// no dependencies; used by kdm_ctrl, kdm_datapath and kway_descending_merge

package kdm_pkg;

	localparam int MAX_LISTS_DEF  = 32;
	localparam int VALUE_BITS_DEF = 31;
	localparam int CFG_BITS       = 6;
	localparam int ID_BITS        = 5;

	localparam logic [CFG_BITS-1:0] NUM_LISTS_RST = 6'd4;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_REFILL = 1'b1;

	typedef enum logic [3:0] {
		ST_LOAD  = 4'b0001,
		ST_SORT  = 4'b0010,
		ST_EMIT  = 4'b0100,
		ST_MERGE = 4'b1000
	} kdm_state_t;

	// commands from the controller to the head array
	typedef struct packed {
		logic load_wr;
		logic sort_step;
		logic refill;
	} kdm_cmd_t;

	typedef struct packed {
		logic top_zero;
	} kdm_status_t;

endpackage

// ----- hw/rtl/kdm_datapath.sv -----
`timescale 1ns / 1ps
// kdm_datapath: row of head cells with parallel compare-and-shift insertion
// depends on kdm_pkg; driven by kdm_ctrl

module kdm_datapath import kdm_pkg::*; #(
	parameter int MAX_LISTS  = MAX_LISTS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	localparam int CNT_W     = $clog2(MAX_LISTS + 1),
	localparam int IDX_W     = $clog2(MAX_LISTS)
) (
	input  logic                  clk,
	input  kdm_cmd_t              cmd,
	input  logic [CNT_W-1:0]      load_count,
	input  logic [CNT_W-1:0]      sort_idx,
	input  logic [CNT_W-1:0]      active_n,
	input  logic [VALUE_BITS-1:0] value,
	output kdm_status_t           status,
	output logic [VALUE_BITS-1:0] merged_value,
	output logic [ID_BITS-1:0]    refill_list
);

	logic [VALUE_BITS-1:0] cell_val [MAX_LISTS];
	logic [ID_BITS-1:0]    cell_id  [MAX_LISTS];
	logic                  ge       [MAX_LISTS];
	logic                  lt       [MAX_LISTS];
	logic [VALUE_BITS-1:0] sort_val;
	logic [ID_BITS-1:0]    sort_id;
	logic [ID_BITS-1:0]    load_id;
	logic [ID_BITS-1:0]    top_id;

	// element being inserted into the sorted prefix during the sort pass
	assign sort_val = cell_val[sort_idx[IDX_W-1:0]];
	assign sort_id  = cell_id[sort_idx[IDX_W-1:0]];
	assign load_id  = ID_BITS'(load_count);
	assign top_id   = cell_id[0];

	for (genvar g = 0; g < MAX_LISTS; g++) begin : g_cell
		logic [VALUE_BITS-1:0] val_q, val_d, up_val, dn_val;
		logic [ID_BITS-1:0]    id_q, id_d, up_id, dn_id;
		logic                  ge_up, lt_up;

		if (g == 0) begin : g_first
			assign up_val = '0;
			assign up_id  = '0;
			assign ge_up  = 1'b1;
			assign lt_up  = 1'b1;
		end else begin : g_mid
			assign up_val = cell_val[g-1];
			assign up_id  = cell_id[g-1];
			assign ge_up  = ge[g-1];
			assign lt_up  = lt[g-1];
		end

		// lt: refill value sinks past this cell's lower neighbor
		if (g == MAX_LISTS - 1) begin : g_last
			assign dn_val = '0;
			assign dn_id  = '0;
			assign lt[g]  = 1'b0;
		end else begin : g_inner
			assign dn_val = cell_val[g+1];
			assign dn_id  = cell_id[g+1];
			assign lt[g]  = (CNT_W'(g + 1) < active_n) && (value < cell_val[g+1]);
		end

		// ge: cell stays ahead of the element being sorted in (stable)
		assign ge[g] = (CNT_W'(g) < sort_idx) && (val_q >= sort_val);

		always_comb begin
			val_d = val_q;
			id_d  = id_q;
			if (cmd.load_wr && load_count == CNT_W'(g)) begin
				val_d = value;
				id_d  = load_id;
			end else if (cmd.sort_step && CNT_W'(g) <= sort_idx) begin
				if (!ge[g]) begin
					if (ge_up) begin
						val_d = sort_val;
						id_d  = sort_id;
					end else begin
						val_d = up_val;
						id_d  = up_id;
					end
				end
			end else if (cmd.refill && CNT_W'(g) < active_n) begin
				if (lt[g]) begin
					val_d = dn_val;
					id_d  = dn_id;
				end else if (lt_up) begin
					val_d = value;
					id_d  = top_id;
				end
			end
		end

		always_ff @(posedge clk) begin
			val_q <= val_d;
			id_q  <= id_d;
		end

		assign cell_val[g] = val_q;
		assign cell_id[g]  = id_q;
	end

	assign status.top_zero = (cell_val[0] == '0);
	assign merged_value    = cell_val[0];
	assign refill_list     = status.top_zero ? '0 : top_id;

endmodule

// ----- hw/rtl/kdm_ctrl.sv -----
`timescale 1ns / 1ps
// kdm_ctrl: phase state machine, load counter, list count register and sort sequencer
// depends on kdm_pkg; drives kdm_datapath

module kdm_ctrl import kdm_pkg::*; #(
	parameter int MAX_LISTS = MAX_LISTS_DEF,
	localparam int CNT_W    = $clog2(MAX_LISTS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [CFG_BITS-1:0] cfg_wr_data,
	input  logic                start,
	input  logic                op,
	input  kdm_status_t         status,
	output logic                busy,
	output logic                result_valid,
	output logic                done_res,
	output kdm_cmd_t            cmd,
	output logic [CNT_W-1:0]    load_count,
	output logic [CNT_W-1:0]    sort_idx,
	output logic [CNT_W-1:0]    active_n
);

	localparam int CMP_W = (CNT_W > CFG_BITS) ? CNT_W : CFG_BITS;

	kdm_state_t          state_q;
	logic [CFG_BITS-1:0] num_lists_q;
	logic [CNT_W-1:0]    load_count_q;
	logic [CNT_W-1:0]    sort_idx_q;
	logic [CNT_W-1:0]    active_n_q;
	logic [CMP_W-1:0]    cfg_ext;
	logic [CMP_W-1:0]    max_ext;
	logic [CMP_W-1:0]    eff_ext;
	logic [CNT_W-1:0]    eff_n;
	logic [CNT_W-1:0]    cnt_next;
	logic                accept;
	logic                load_go;
	logic                load_done;
	logic                refill_go;

	// clamp the list count to 1..MAX_LISTS
	assign cfg_ext = CMP_W'(num_lists_q);
	assign max_ext = CMP_W'(MAX_LISTS);
	assign eff_ext = (cfg_ext == '0) ? CMP_W'(1) : ((cfg_ext > max_ext) ? max_ext : cfg_ext);
	assign eff_n   = CNT_W'(eff_ext);

	assign busy      = !(state_q == ST_LOAD || state_q == ST_MERGE);
	assign accept    = start && !busy;
	assign load_go   = accept && (state_q == ST_LOAD) && (op == OP_LOAD);
	assign refill_go = accept && (state_q == ST_MERGE) && (op == OP_REFILL);
	assign cnt_next  = (load_count_q < CNT_W'(MAX_LISTS)) ? load_count_q + CNT_W'(1)
	                                                      : load_count_q;
	assign load_done = load_go && (cnt_next >= eff_n);

	assign cmd.load_wr   = load_go && (load_count_q < CNT_W'(MAX_LISTS));
	assign cmd.sort_step = (state_q == ST_SORT) && (sort_idx_q < active_n_q);
	assign cmd.refill    = refill_go;

	assign result_valid = (state_q == ST_EMIT);
	assign done_res     = result_valid && status.top_zero;
	assign load_count   = load_count_q;
	assign sort_idx     = sort_idx_q;
	assign active_n     = active_n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_lists_q <= NUM_LISTS_RST;
		end else if (cfg_wr_en) begin
			num_lists_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			load_count_q <= '0;
			sort_idx_q   <= '0;
			active_n_q   <= CNT_W'(1);
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (load_go) begin
						load_count_q <= cnt_next;
					end
					if (load_done) begin
						active_n_q <= eff_n;
						sort_idx_q <= CNT_W'(1);
						state_q    <= ST_SORT;
					end
				end
				ST_SORT: begin
					if (sort_idx_q < active_n_q) begin
						sort_idx_q <= sort_idx_q + CNT_W'(1);
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (status.top_zero) begin
						load_count_q <= '0;
						state_q      <= ST_LOAD;
					end else begin
						state_q <= ST_MERGE;
					end
				end
				ST_MERGE: begin
					if (refill_go) begin
						state_q <= ST_EMIT;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	a_single_word: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("two result words in a row");

	a_done_reload: assert property (@(posedge clk) disable iff (!arst_n)
		done_res |=> (state_q == ST_LOAD && load_count_q == '0))
		else $error("done did not return to load phase");

	a_refill_result: assert property (@(posedge clk) disable iff (!arst_n)
		refill_go |=> result_valid)
		else $error("refill word gave no result");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		load_count_q <= CNT_W'(MAX_LISTS))
		else $error("load count beyond list capacity");

	a_sort_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SORT) |-> (sort_idx_q != '0 && sort_idx_q <= active_n_q))
		else $error("sort index out of range");

endmodule

// ----- hw/rtl/kway_descending_merge.sv -----
`timescale 1ns / 1ps
// kway_descending_merge: top level of the k-way descending merge
// depends on kdm_pkg, kdm_ctrl and kdm_datapath

// Load words (op 0) bring list heads in index order, one per cycle while busy is low.
// The word that completes the load starts a sort pass over the n heads (n = list
// count, clamped and latched at that point), one insertion per cycle through the
// head cells, then the top value is emitted. Each refill word (op 1) is inserted
// in the cycle it is taken and its result appears in the next cycle; busy is high
// in the result cycle, so no word is taken. A result is on the ports for one cycle
// only, marked by result_valid, and cannot be held off: the receiver must take it.
// done_res marks the end of the merge, after which the block is back in load phase.
// The list count register may only be written while the block is idle.

module kway_descending_merge import kdm_pkg::*; #(
	parameter int MAX_LISTS  = MAX_LISTS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_BITS-1:0]   cfg_wr_data,
	input  logic                  start,
	output logic                  busy,
	input  logic                  op,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  result_valid,
	output logic [VALUE_BITS-1:0] merged_value,
	output logic [ID_BITS-1:0]    refill_list,
	output logic                  done_res
);

	localparam int CNT_W = $clog2(MAX_LISTS + 1);

	kdm_cmd_t         cmd;
	kdm_status_t      status;
	logic [CNT_W-1:0] load_count;
	logic [CNT_W-1:0] sort_idx;
	logic [CNT_W-1:0] active_n;

	kdm_ctrl #(
		.MAX_LISTS (MAX_LISTS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.start        (start),
		.op           (op),
		.status       (status),
		.busy         (busy),
		.result_valid (result_valid),
		.done_res     (done_res),
		.cmd          (cmd),
		.load_count   (load_count),
		.sort_idx     (sort_idx),
		.active_n     (active_n)
	);

	kdm_datapath #(
		.MAX_LISTS  (MAX_LISTS),
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk          (clk),
		.cmd          (cmd),
		.load_count   (load_count),
		.sort_idx     (sort_idx),
		.active_n     (active_n),
		.value        (value),
		.status       (status),
		.merged_value (merged_value),
		.refill_list  (refill_list)
	);

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// testbench: self-checking bench for kway_descending_merge, with a scoreboard class
// that predicts the merged stream; depends on kdm_pkg and the kway_descending_merge rtl

import kdm_pkg::*;

localparam int VB = VALUE_BITS_DEF;

typedef struct packed {
	logic [VB-1:0]      merged;
	logic [ID_BITS-1:0] list;
	logic               done;
} merge_out_t;

class merge_scoreboard;
	logic [VB-1:0]       head_val [MAX_LISTS_DEF];
	logic [ID_BITS-1:0]  head_id [MAX_LISTS_DEF];
	int                  load_cnt;
	bit                  merging;
	int                  active_n;
	logic [CFG_BITS-1:0] num_lists;
	logic [ID_BITS-1:0]  want_list;
	int                  errors;
	merge_out_t          upcoming_outputs[$];

	function new();
		load_cnt = 0;
		merging = 1'b0;
		active_n = 1;
		num_lists = NUM_LISTS_RST;
		want_list = '0;
		errors = 0;
	endfunction

	function void write_lists(logic [CFG_BITS-1:0] cnt);
		num_lists = cnt;
	endfunction

	function int lists_in_use();
		int n;
		n = num_lists;
		if (n < 1) n = 1;
		if (n > MAX_LISTS_DEF) n = MAX_LISTS_DEF;
		return n;
	endfunction

	function int pending();
		return upcoming_outputs.size();
	endfunction

	// stable descending insertion sort of the loaded heads
	function void sort_heads();
		logic [VB-1:0]      v;
		logic [ID_BITS-1:0] id;
		int                 j;
		for (int i = 1; i < active_n; i++) begin
			v = head_val[i];
			id = head_id[i];
			j = i;
			while (j > 0 && head_val[j-1] < v) begin
				head_val[j] = head_val[j-1];
				head_id[j] = head_id[j-1];
				j--;
			end
			head_val[j] = v;
			head_id[j] = id;
		end
	endfunction

	// new value replaces the top and sinks ahead of equal values
	function void refill_top(logic [VB-1:0] v);
		logic [ID_BITS-1:0] id;
		int                 j;
		id = head_id[0];
		j = 0;
		while (j + 1 < active_n && v < head_val[j+1]) begin
			head_val[j] = head_val[j+1];
			head_id[j] = head_id[j+1];
			j++;
		end
		head_val[j] = v;
		head_id[j] = id;
	endfunction

	function void emit_top();
		merge_out_t o;
		if (head_val[0] == '0) begin
			o.merged = '0;
			o.list = '0;
			o.done = 1'b1;
			merging = 1'b0;
			load_cnt = 0;
		end else begin
			o.merged = head_val[0];
			o.list = head_id[0];
			o.done = 1'b0;
			want_list = head_id[0];
		end
		upcoming_outputs.push_back(o);
	endfunction

	// returns 1 when the word is used, 0 when the block ignores it
	function bit take_word(logic w_op, logic [VB-1:0] v);
		if (!merging) begin
			if (w_op != OP_LOAD) return 1'b0;
			if (load_cnt < MAX_LISTS_DEF) begin
				head_val[load_cnt] = v;
				head_id[load_cnt] = ID_BITS'(load_cnt);
				load_cnt++;
			end
			if (load_cnt < lists_in_use()) return 1'b1;
			active_n = lists_in_use();
			merging = 1'b1;
			sort_heads();
			emit_top();
			return 1'b1;
		end
		if (w_op != OP_REFILL) return 1'b0;
		refill_top(v);
		emit_top();
		return 1'b1;
	endfunction

	function void check_output(logic [VB-1:0] mv, logic [ID_BITS-1:0] rl, logic dn);
		merge_out_t e;
		if (upcoming_outputs.size() == 0) begin
			$display("%0t: unexpected word: merged_value %0d refill_list %0d done_res %0b",
				$time, mv, rl, dn);
			errors++;
			return;
		end
		e = upcoming_outputs.pop_front();
		if (mv !== e.merged) begin
			$display("%0t: merged_value expected %0d, got %0d", $time, e.merged, mv);
			errors++;
		end
		if (rl !== e.list) begin
			$display("%0t: refill_list expected %0d, got %0d", $time, e.list, rl);
			errors++;
		end
		if (dn !== e.done) begin
			$display("%0t: done_res expected %0b, got %0b", $time, e.done, dn);
			errors++;
		end
	endfunction
endclass

module testbench;
	localparam int LIMIT = 400000;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [CFG_BITS-1:0] cfg_wr_data;
	logic                start;
	logic                busy;
	logic                op;
	logic [VB-1:0]       value;
	logic                result_valid;
	logic [VB-1:0]       merged_value;
	logic [ID_BITS-1:0]  refill_list;
	logic                done_res;

	merge_scoreboard sb;
	int              word_count;
	logic [VB-1:0]   list_mem [MAX_LISTS_DEF][16];
	int              list_pos [MAX_LISTS_DEF];

	kway_descending_merge u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.value        (value),
		.result_valid (result_valid),
		.merged_value (merged_value),
		.refill_list  (refill_list),
		.done_res     (done_res)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid)
			sb.check_output(merged_value, refill_list, done_res);
	end

	initial begin : watchdog
		int cyc;
		cyc = 0;
		while (cyc < LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("status: fail");
		$finish;
	end

	function automatic logic [VB-1:0] rand_value();
		if ($urandom_range(3) == 0)
			return VB'($urandom_range(7));
		return VB'($urandom);
	endfunction

	task automatic pause_sender(int unsigned k);
		@(negedge clk);
		start <= 1'b0;
		repeat (k - 1) @(negedge clk);
	endtask

	task automatic send_word(logic w_op, logic [VB-1:0] w_val);
		int unsigned idle_pct;
		idle_pct = (word_count < 350) ? 37 : (word_count < 700) ? 67 : 0;
		if ($urandom_range(99) < idle_pct)
			pause_sender($urandom_range(1, 4));
		@(negedge clk);
		start <= 1'b1;
		op <= w_op;
		value <= w_val;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (sb.take_word(w_op, w_val))
			word_count++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_list_count(logic [CFG_BITS-1:0] cnt);
		drain_results();
		// a load may still be in its sort pass
		repeat (36) @(posedge clk);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= cnt;
		@(posedge clk);
		sb.write_lists(cnt);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic fill_list(int idx, logic [VB-1:0] e0, logic [VB-1:0] e1,
			logic [VB-1:0] e2, logic [VB-1:0] e3);
		for (int k = 0; k < 16; k++) list_mem[idx][k] = '0;
		list_mem[idx][0] = e0;
		list_mem[idx][1] = e1;
		list_mem[idx][2] = e2;
		list_mem[idx][3] = e3;
	endtask

	task automatic build_lists(int n);
		int            max_len;
		int            len;
		bit            narrow;
		logic [VB-1:0] v;
		max_len = (n > 8) ? 3 : 8;
		narrow = 1'($urandom_range(1));
		for (int i = 0; i < n; i++) begin
			for (int k = 0; k < 16; k++) list_mem[i][k] = '0;
			len = $urandom_range(max_len);
			if (narrow)
				v = VB'($urandom_range(6, 1));
			else if ($urandom_range(7) == 0)
				v = '1;
			else
				v = VB'($urandom_range(32'h7fffffff, 1));
			for (int k = 0; k < len; k++) begin
				list_mem[i][k] = v;
				if ($urandom_range(3) != 0)
					v = VB'($urandom_range(v, 1));
			end
		end
	endtask

	// loads the heads, then answers every refill request until done
	task automatic merge_pass(int unsigned stray_pct, int unsigned bad_budget);
		int            n;
		int            id;
		logic [VB-1:0] v;
		n = sb.lists_in_use();
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < stray_pct)
				send_word(OP_REFILL, rand_value());
			send_word(OP_LOAD, list_mem[i][0]);
			list_pos[i] = 1;
		end
		while (sb.merging) begin
			if ($urandom_range(99) < stray_pct)
				send_word(OP_LOAD, rand_value());
			if ($urandom_range(99) == 0)
				drain_results();
			id = sb.want_list;
			if (bad_budget != 0 && $urandom_range(19) == 0) begin
				v = rand_value();
				bad_budget--;
			end else begin
				v = (list_pos[id] < 16) ? list_mem[id][list_pos[id]] : '0;
				list_pos[id]++;
			end
			send_word(OP_REFILL, v);
		end
	endtask

	function automatic logic [CFG_BITS-1:0] pick_count();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60) return CFG_BITS'($urandom_range(8, 2));
		if (r < 75) return CFG_BITS'($urandom_range(31, 9));
		if (r < 82) return '0;
		if (r < 88) return CFG_BITS'(1);
		if (r < 94) return CFG_BITS'(MAX_LISTS_DEF);
		return CFG_BITS'($urandom_range(63, 33));
	endfunction

	initial begin
		sb = new();
		word_count = 0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		start = 1'b0;
		op = OP_LOAD;
		value = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset list count: refill in load phase, ties, max value, empty list
		send_word(OP_REFILL, VB'(32'h1234));
		fill_list(0, 5, 1, 0, 0);
		fill_list(1, 31'h7fffffff, 5, 0, 0);
		fill_list(2, 5, 0, 0, 0);
		fill_list(3, 0, 0, 0, 0);
		merge_pass(20, 0);

		write_list_count(CFG_BITS'(1));
		fill_list(0, 31'h7fffffff, 31'h55555555, 31'h2aaaaaaa, 1);
		merge_pass(0, 0);
		fill_list(0, 0, 0, 0, 0);
		merge_pass(0, 0);

		// zero count acts as one list
		write_list_count('0);
		fill_list(0, 1, 0, 0, 0);
		merge_pass(0, 0);

		write_list_count(CFG_BITS'(MAX_LISTS_DEF));
		build_lists(sb.lists_in_use());
		merge_pass(5, 0);
		write_list_count('1);
		build_lists(sb.lists_in_use());
		merge_pass(5, 1);

		while (word_count < 1050) begin
			if ($urandom_range(2) == 0)
				write_list_count(pick_count());
			build_lists(sb.lists_in_use());
			merge_pass(8, $urandom_range(3));
		end

		drain_results();
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
